@@ rtl/pbpu_pkg.sv @@
// ----------------------------------------------------------------------------
// pbpu_pkg: shared types and constants of the packet bit packer/unpacker
// Action and status codes, field widths and the default buffer size.
// ----------------------------------------------------------------------------
`default_nettype none

package pbpu_pkg;

  // Default number of bytes in the packet buffer.
  localparam int unsigned DEF_BUFFER_BYTES = 1024;

  // Field widths.
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned ACT_W  = 3;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned BIT_W  = 3;

  // Requested operation, carried in the input tuser.
  typedef enum logic [ACT_W-1:0] {
    ACT_BEGIN_WRITE = 3'd0,
    ACT_WRITE_BYTE  = 3'd1,
    ACT_WRITE_BIT   = 3'd2,
    ACT_BEGIN_READ  = 3'd3,
    ACT_READ_BYTE   = 3'd4,
    ACT_READ_BIT    = 3'd5
  } act_e;

  // Result status of one transfer.
  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_UNDERRUN = 2'd2
  } stat_e;

endpackage : pbpu_pkg

`default_nettype wire

@@ rtl/pbpu_ram.sv @@
// ----------------------------------------------------------------------------
// pbpu_ram: generic single-port RAM
// One access per cycle; the read data is registered and holds until the next
// read.
// ----------------------------------------------------------------------------
`default_nettype none

module pbpu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write or registered read at one address.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule : pbpu_ram

`default_nettype wire

@@ rtl/packet_bit_packer_unpacker.sv @@
// ----------------------------------------------------------------------------
// packet_bit_packer_unpacker: LSB-first bit and byte packer/unpacker
// Packs bytes and single bits at any bit offset into one packet buffer and
// unpacks them again, reporting overflow on writes and underrun on reads.
// ----------------------------------------------------------------------------
// The block works on one transfer at a time and answers each with exactly one
// result transfer. The buffer lives in a single-port RAM with a registered
// read, so an action is a run of RAM steps: begin_write, begin_read, unknown
// and rejected actions and zero-bit writes into an open byte need no access;
// aligned byte writes and bit writes that open a byte write once; aligned
// byte reads, bit reads and one-bit writes into an open byte read, then use
// or write back; unaligned byte writes and reads touch two buffer bytes. While
// a result still waits in the output register the next transfer is accepted;
// it stalls only when its own result is ready before the previous one has been
// taken. The buffer needs no clearing after reset: only bytes written since
// the last begin_write are ever read.
`default_nettype none

module packet_bit_packer_unpacker #(
  parameter int unsigned BUFFER_BYTES = pbpu_pkg::DEF_BUFFER_BYTES
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  // Input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] value
  input  wire logic [pbpu_pkg::ACT_W-1:0] s_axis_tuser, // [2:0] action
  // Output stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] read_data, [9:8] status, then used_bytes, zero filled to bytes
  output logic [((pbpu_pkg::BYTE_W + pbpu_pkg::STAT_W + $clog2(BUFFER_BYTES + 1) + 7) / 8)
                * 8 - 1:0] m_axis_tdata
);

  import pbpu_pkg::*;

  localparam int unsigned AW    = $clog2(BUFFER_BYTES);
  localparam int unsigned CW    = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned OUT_W = ((BYTE_W + STAT_W + CW + 7) / 8) * 8;

  localparam logic [CW-1:0]    BufLast  = CW'(BUFFER_BYTES);
  localparam logic [CW:0]      BufLastX = (CW + 1)'(BUFFER_BYTES);
  localparam logic [BIT_W-1:0] BitLast  = BIT_W'(BYTE_W - 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD1  = 5'b00010,
    S_RD2  = 5'b00100,
    S_WHI  = 5'b01000,
    S_HOLD = 5'b10000
  } state_e;

  // Control state
  state_e           state_q, state_d;
  logic [CW-1:0]    wpos_q, wpos_d;
  logic [BIT_W-1:0] wbit_q, wbit_d;
  logic [CW-1:0]    size_q, size_d;
  logic [CW-1:0]    rpos_q, rpos_d;
  logic [BIT_W-1:0] rbit_q, rbit_d;
  logic             m_valid_q, m_valid_d;

  // Payload registers
  act_e              op_q, op_d;
  logic [BYTE_W-1:0] val_q, val_d;
  logic [BYTE_W-1:0] lo_q, lo_d;
  logic [BYTE_W-1:0] hold_data_q, hold_data_d;
  stat_e             hold_status_q, hold_status_d;
  logic [BYTE_W-1:0] m_data_q, m_data_d;
  stat_e             m_status_q, m_status_d;
  logic [CW-1:0]     m_used_q, m_used_d;

  // RAM port
  logic              ram_en;
  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [BYTE_W-1:0] ram_wdata;
  logic [BYTE_W-1:0] ram_rdata;

  // Result of the current step
  logic              fin;
  logic [BYTE_W-1:0] fin_data;
  stat_e             fin_status;

  logic              s_fire;
  logic              out_free;
  act_e              in_act;
  logic [BYTE_W-1:0] in_val;
  logic [CW:0]       wpos_inc;
  logic [CW:0]       rpos_inc;
  logic [3:0]        wsh_inv;
  logic [3:0]        rsh_inv;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign in_act        = act_e'(s_axis_tuser);
  assign in_val        = s_axis_tdata;
  assign wpos_inc      = {1'b0, wpos_q} + 1'b1;
  assign rpos_inc      = {1'b0, rpos_q} + 1'b1;
  assign wsh_inv       = 4'(4'(BYTE_W) - {1'b0, wbit_q});
  assign rsh_inv       = 4'(4'(BYTE_W) - {1'b0, rbit_q});

  // Buffer memory
  pbpu_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUFFER_BYTES)
  ) u_buf (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Sequencer: decode on acceptance, then read, modify and write back.
  always_comb begin
    state_d    = state_q;
    wpos_d     = wpos_q;
    wbit_d     = wbit_q;
    size_d     = size_q;
    rpos_d     = rpos_q;
    rbit_d     = rbit_q;
    op_d       = op_q;
    val_d      = val_q;
    lo_d       = lo_q;
    ram_en     = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = '0;
    ram_wdata  = '0;
    fin        = 1'b0;
    fin_data   = '0;
    fin_status = ST_OK;

    case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          op_d  = in_act;
          val_d = in_val;
          case (in_act)
            ACT_BEGIN_WRITE: begin
              size_d = '0;
              wpos_d = '0;
              wbit_d = '0;
              fin    = 1'b1;
            end
            ACT_WRITE_BYTE: begin
              if (wbit_q == '0) begin
                if (wpos_q >= BufLast) begin
                  fin_status = ST_OVERFLOW;
                  fin        = 1'b1;
                end else begin
                  ram_en    = 1'b1;
                  ram_we    = 1'b1;
                  ram_addr  = wpos_q[AW-1:0];
                  ram_wdata = in_val;
                  wpos_d    = CW'(wpos_inc);
                  size_d    = CW'(size_q + 1'b1);
                  fin       = 1'b1;
                end
              end else if (wpos_inc >= BufLastX) begin
                fin_status = ST_OVERFLOW;
                fin        = 1'b1;
              end else begin
                // Fetch the open byte to merge the low part into it.
                ram_en   = 1'b1;
                ram_addr = wpos_q[AW-1:0];
                state_d  = S_RD1;
              end
            end
            ACT_WRITE_BIT: begin
              if (wpos_q >= BufLast) begin
                fin_status = ST_OVERFLOW;
                fin        = 1'b1;
              end else if (wbit_q == '0) begin
                // A bit at offset zero opens a new byte.
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_addr  = wpos_q[AW-1:0];
                ram_wdata = {{(BYTE_W - 1){1'b0}}, in_val[0]};
                wbit_d    = BIT_W'(1);
                size_d    = CW'(size_q + 1'b1);
                fin       = 1'b1;
              end else if (in_val[0]) begin
                ram_en   = 1'b1;
                ram_addr = wpos_q[AW-1:0];
                state_d  = S_RD1;
              end else begin
                // A zero bit only moves the cursor.
                if (wbit_q == BitLast) begin
                  wbit_d = '0;
                  wpos_d = CW'(wpos_inc);
                end else begin
                  wbit_d = BIT_W'(wbit_q + 1'b1);
                end
                fin = 1'b1;
              end
            end
            ACT_BEGIN_READ: begin
              rpos_d = '0;
              rbit_d = '0;
              fin    = 1'b1;
            end
            ACT_READ_BYTE: begin
              if (rpos_q >= size_q) begin
                fin_status = ST_UNDERRUN;
                fin        = 1'b1;
              end else if ((rbit_q != '0) && (rpos_inc >= {1'b0, size_q})) begin
                fin_status = ST_UNDERRUN;
                fin        = 1'b1;
              end else begin
                ram_en   = 1'b1;
                ram_addr = rpos_q[AW-1:0];
                state_d  = S_RD1;
              end
            end
            ACT_READ_BIT: begin
              if (rpos_q >= size_q) begin
                fin_status = ST_UNDERRUN;
                fin        = 1'b1;
              end else begin
                ram_en   = 1'b1;
                ram_addr = rpos_q[AW-1:0];
                state_d  = S_RD1;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      S_RD1: begin
        case (op_q)
          ACT_WRITE_BYTE: begin
            // Merge the low part into the open byte.
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = wpos_q[AW-1:0];
            ram_wdata = ram_rdata | BYTE_W'(val_q << wbit_q);
            state_d   = S_WHI;
          end
          ACT_WRITE_BIT: begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = wpos_q[AW-1:0];
            ram_wdata = ram_rdata | BYTE_W'(1'b1 << wbit_q);
            if (wbit_q == BitLast) begin
              wbit_d = '0;
              wpos_d = CW'(wpos_inc);
            end else begin
              wbit_d = BIT_W'(wbit_q + 1'b1);
            end
            fin = 1'b1;
          end
          ACT_READ_BYTE: begin
            if (rbit_q == '0) begin
              fin_data = ram_rdata;
              rpos_d   = CW'(rpos_inc);
              fin      = 1'b1;
            end else begin
              // Keep the low part and fetch the next byte.
              lo_d     = ram_rdata >> rbit_q;
              ram_en   = 1'b1;
              ram_addr = rpos_inc[AW-1:0];
              state_d  = S_RD2;
            end
          end
          ACT_READ_BIT: begin
            fin_data = {{(BYTE_W - 1){1'b0}}, ram_rdata[rbit_q]};
            if (rbit_q == BitLast) begin
              rbit_d = '0;
              rpos_d = CW'(rpos_inc);
            end else begin
              rbit_d = BIT_W'(rbit_q + 1'b1);
            end
            fin = 1'b1;
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end

      S_RD2: begin
        fin_data = lo_q | BYTE_W'(ram_rdata << rsh_inv);
        rpos_d   = CW'(rpos_inc);
        fin      = 1'b1;
      end

      S_WHI: begin
        // The high part starts a fresh byte.
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = wpos_inc[AW-1:0];
        ram_wdata = val_q >> wsh_inv;
        wpos_d    = CW'(wpos_inc);
        size_d    = CW'(size_q + 1'b1);
        fin       = 1'b1;
      end

      S_HOLD: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // A finished result goes to the output register, or waits if it is full.
    if (fin) begin
      state_d = out_free ? S_IDLE : S_HOLD;
    end
  end

  // Output register and hold stage.
  always_comb begin
    m_valid_d     = m_valid_q && !m_axis_tready;
    m_data_d      = m_data_q;
    m_status_d    = m_status_q;
    m_used_d      = m_used_q;
    hold_data_d   = hold_data_q;
    hold_status_d = hold_status_q;
    if (fin) begin
      if (out_free) begin
        m_valid_d  = 1'b1;
        m_data_d   = fin_data;
        m_status_d = fin_status;
        m_used_d   = size_d;
      end else begin
        hold_data_d   = fin_data;
        hold_status_d = fin_status;
      end
    end else if ((state_q == S_HOLD) && out_free) begin
      m_valid_d  = 1'b1;
      m_data_d   = hold_data_q;
      m_status_d = hold_status_q;
      m_used_d   = size_q;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      wpos_q    <= '0;
      wbit_q    <= '0;
      size_q    <= '0;
      rpos_q    <= '0;
      rbit_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wpos_q    <= wpos_d;
      wbit_q    <= wbit_d;
      size_q    <= size_d;
      rpos_q    <= rpos_d;
      rbit_q    <= rbit_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q          <= op_d;
    val_q         <= val_d;
    lo_q          <= lo_d;
    hold_data_q   <= hold_data_d;
    hold_status_q <= hold_status_d;
    m_data_q      <= m_data_d;
    m_status_q    <= m_status_d;
    m_used_q      <= m_used_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_W'({m_used_q, m_status_q, m_data_q});

  // The used size always covers the write cursor plus an open byte.
  a_size_tracks_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wbit_q == '0) ? (size_q == wpos_q) : (size_q == CW'(wpos_q + 1'b1)))
    else $error("used size out of step with the write cursor");

  // An open byte always lies inside the buffer.
  a_open_byte_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wbit_q != '0) |-> (wpos_q < BufLast))
    else $error("open write byte beyond the buffer");

  // Read data is only consumed in the cycle after a RAM read.
  a_read_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD1 || state_q == S_RD2) |-> $past(ram_en && !ram_we))
    else $error("read data used without a preceding read");

  // The second access of an unaligned byte follows the first one directly.
  a_phase_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD2 || state_q == S_WHI) |-> $past(state_q) == S_RD1)
    else $error("second byte access out of order");

  // An underrun never returns data.
  a_underrun_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_status_q == ST_UNDERRUN) |-> (m_data_q == '0))
    else $error("underrun result carries data");

endmodule : packet_bit_packer_unpacker

`default_nettype wire
